// ----- src/bfbp_pkg.sv -----
`default_nettype none

package bfbp_pkg;

	// default sizing
	localparam int MAX_BINS_DEF    = 64;
	localparam int WEIGHT_BITS_DEF = 16;

	// port widths fixed by the interface
	localparam int CAP_W    = 16;
	localparam int ITEM_W   = 16;
	localparam int STATUS_W = 3;
	localparam int BIN_W    = 6;
	localparam int USED_W   = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 16'd10;

	typedef enum logic [STATUS_W-1:0] {
		ST_EXISTING = 3'd0,
		ST_NEW      = 3'd1,
		ST_ZERO     = 3'd2,
		ST_HEAVY    = 3'd3,
		ST_FULL     = 3'd4,
		ST_FAILED   = 3'd5
	} status_t;

endpackage

`default_nettype wire

// ----- src/bfbp_cell.sv -----
`default_nettype none

// One bin of the table: holds its room left and folds itself into the
// running best-fit candidate that travels down the chain.
module bfbp_cell #(
	parameter int CELL_IDX    = 0,
	parameter int MAX_BINS    = bfbp_pkg::MAX_BINS_DEF,
	parameter int WEIGHT_BITS = bfbp_pkg::WEIGHT_BITS_DEF,
	localparam int IDX_W      = $clog2(MAX_BINS),
	localparam int CNT_W      = $clog2(MAX_BINS + 1)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic [WEIGHT_BITS-1:0] w,
	input  wire logic [CNT_W-1:0]       open_cnt,
	input  wire logic                   found_in,
	input  wire logic [WEIGHT_BITS-1:0] room_in,
	input  wire logic [IDX_W-1:0]       idx_in,
	input  wire logic                   upd_en,
	input  wire logic [IDX_W-1:0]       upd_idx,
	input  wire logic [WEIGHT_BITS-1:0] upd_room,
	output logic                        found_out,
	output logic [WEIGHT_BITS-1:0]      room_out,
	output logic [IDX_W-1:0]            idx_out
);

	logic [WEIGHT_BITS-1:0] room_q;
	logic                   opened;
	logic                   take;

	// bins open in the set form a prefix of the table
	assign opened = CNT_W'(CELL_IDX) < open_cnt;
	// strict compare keeps the lower index on a tie
	assign take   = opened && (room_q >= w) && (!found_in || (room_q < room_in));

	always_ff @(posedge clk) begin
		if (upd_en && (upd_idx == IDX_W'(CELL_IDX))) begin
			room_q <= upd_room;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_out <= 1'b0;
		end else begin
			found_out <= found_in || take;
		end
	end

	always_ff @(posedge clk) begin
		room_out <= take ? room_q : room_in;
		idx_out  <= take ? IDX_W'(CELL_IDX) : idx_in;
	end

endmodule

`default_nettype wire

// ----- src/best_fit_bin_packer_core.sv -----
`default_nettype none

// A rejected word (set failed, zero weight, too heavy) is answered from the idle
// state with a done strobe; a placed word first runs the scan and resolve states.
// A placed word holds busy high while the candidate walks the bin chain one cell
// per cycle, so no new word is taken until it is done; rejected words go 1/cycle.
// The receiver cannot stall: each result shows for exactly one cycle on done.
// Reset (arst_n low, async): no bins open, set not failed, capacity 10.
module best_fit_bin_packer_core #(
	parameter int MAX_BINS    = bfbp_pkg::MAX_BINS_DEF,
	parameter int WEIGHT_BITS = bfbp_pkg::WEIGHT_BITS_DEF,
	localparam int IDX_W      = $clog2(MAX_BINS),
	localparam int CNT_W      = $clog2(MAX_BINS + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// command side
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [bfbp_pkg::ITEM_W-1:0]   item_weight,
	input  wire logic                          last_item,
	// capacity register
	input  wire logic                          cfg_we,
	input  wire logic [bfbp_pkg::CAP_W-1:0]    cfg_data,
	// result side
	output logic                               done,
	output logic [bfbp_pkg::STATUS_W-1:0]      status,
	output logic [bfbp_pkg::BIN_W-1:0]         bin_index,
	output logic [bfbp_pkg::USED_W-1:0]        bins_used,
	output logic                               set_done
);

	typedef enum logic [2:0] {
		S_IDLE    = 3'b001,
		S_SCAN    = 3'b010,
		S_RESOLVE = 3'b100
	} state_t;

	state_t                        state_q;
	logic [bfbp_pkg::CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]              open_q;
	logic                          failed_q;
	logic [IDX_W-1:0]              cnt_q;
	logic [WEIGHT_BITS-1:0]        w_q;
	logic                          last_q;

	// result word registers
	logic                          done_q;
	bfbp_pkg::status_t             status_q;
	logic [bfbp_pkg::BIN_W-1:0]    bin_q;
	logic [bfbp_pkg::USED_W-1:0]   used_q;
	logic                          set_done_q;

	logic [WEIGHT_BITS-1:0]        w_in;
	logic [WEIGHT_BITS-1:0]        cap_w;
	logic                          table_full;

	// candidate chain: entry 0 is the empty candidate fed to the first cell,
	// entry MAX_BINS is what leaves the last cell
	logic                          found_ch [MAX_BINS+1];
	logic [WEIGHT_BITS-1:0]        room_ch  [MAX_BINS+1];
	logic [IDX_W-1:0]              idx_ch   [MAX_BINS+1];

	// update broadcast to the cells in the resolve cycle
	logic                          upd_en;
	logic [IDX_W-1:0]              upd_idx;
	logic [WEIGHT_BITS-1:0]        upd_room;

	assign w_in       = WEIGHT_BITS'(item_weight);
	assign cap_w      = WEIGHT_BITS'(cap_q);
	assign table_full = (open_q == CNT_W'(MAX_BINS));

	assign found_ch[0] = 1'b0;
	assign room_ch[0]  = '0;
	assign idx_ch[0]   = '0;

	// Every cell recomputes each cycle; with the weight and table held still
	// during the scan, the last cell's output has settled by the resolve state.
	for (genvar k = 0; k < MAX_BINS; k++) begin : g_cell
		bfbp_cell #(
			.CELL_IDX    (k),
			.MAX_BINS    (MAX_BINS),
			.WEIGHT_BITS (WEIGHT_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.w         (w_q),
			.open_cnt  (open_q),
			.found_in  (found_ch[k]),
			.room_in   (room_ch[k]),
			.idx_in    (idx_ch[k]),
			.upd_en    (upd_en),
			.upd_idx   (upd_idx),
			.upd_room  (upd_room),
			.found_out (found_ch[k+1]),
			.room_out  (room_ch[k+1]),
			.idx_out   (idx_ch[k+1])
		);
	end

	// Placing in an existing bin uses the room the chain carried out with the
	// winner; a new bin starts from the capacity.
	always_comb begin
		upd_en   = (state_q == S_RESOLVE) && (found_ch[MAX_BINS] || !table_full);
		upd_idx  = found_ch[MAX_BINS] ? idx_ch[MAX_BINS] : IDX_W'(open_q);
		upd_room = found_ch[MAX_BINS] ? (room_ch[MAX_BINS] - w_q) : (cap_w - w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= bfbp_pkg::CAP_RESET;
			open_q   <= '0;
			failed_q <= 1'b0;
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						// rejects are answered straight away; bins stay as they are unless the set closes
						priority if (failed_q) begin
							done_q <= 1'b1;
						end else if (w_in == '0) begin
							done_q   <= 1'b1;
							failed_q <= 1'b1;
						end else if (w_in > cap_w) begin
							done_q   <= 1'b1;
							failed_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
						// end of set wins over any failure just recorded
						if (last_item && (failed_q || (w_in == '0) || (w_in > cap_w))) begin
							open_q   <= '0;
							failed_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (cnt_q == IDX_W'(MAX_BINS - 1)) begin
						state_q <= S_RESOLVE;
					end
				end
				S_RESOLVE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (!found_ch[MAX_BINS]) begin
						if (table_full) begin
							failed_q <= 1'b1;
						end else begin
							open_q <= open_q + CNT_W'(1);
						end
					end
					if (last_q) begin
						open_q   <= '0;
						failed_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload side of the result word and the latched command
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					w_q        <= w_in;
					last_q     <= last_item;
					bin_q      <= '0;
					used_q     <= bfbp_pkg::USED_W'(open_q);
					set_done_q <= last_item;
					priority if (failed_q) begin
						status_q <= bfbp_pkg::ST_FAILED;
					end else if (w_in == '0) begin
						status_q <= bfbp_pkg::ST_ZERO;
					end else begin
						status_q <= bfbp_pkg::ST_HEAVY;
					end
				end
			end
			S_RESOLVE: begin
				set_done_q <= last_q;
				priority if (found_ch[MAX_BINS]) begin
					status_q <= bfbp_pkg::ST_EXISTING;
					bin_q    <= bfbp_pkg::BIN_W'(idx_ch[MAX_BINS]);
					used_q   <= bfbp_pkg::USED_W'(open_q);
				end else if (table_full) begin
					status_q <= bfbp_pkg::ST_FULL;
					bin_q    <= '0;
					used_q   <= bfbp_pkg::USED_W'(open_q);
				end else begin
					status_q <= bfbp_pkg::ST_NEW;
					bin_q    <= bfbp_pkg::BIN_W'(open_q);
					used_q   <= bfbp_pkg::USED_W'(open_q + CNT_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign bin_index = bin_q;
	assign bins_used = used_q;
	assign set_done  = set_done_q;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;

	import bfbp_pkg::*;

	localparam int NBINS        = MAX_BINS_DEF;
	// The limit sits well above the longest placed word and the longest sender gap,
	// so reaching it means the block has hung.
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 1800;

	// One expected result word.
	typedef struct packed {
		status_t             status;
		logic [BIN_W-1:0]    bin;
		logic [USED_W-1:0]   used;
		logic                set_done;
	} packing_t;

	// One line of the directed plan. A row with set_cap waits for the block to
	// go idle and writes the capacity first. count repeats the same word.
	// typed rows carry a hand-written result instead of the predicted one.
	typedef struct packed {
		logic                set_cap;
		logic [CAP_W-1:0]    cap;
		logic [ITEM_W-1:0]   weight;
		logic                last;
		logic [7:0]          count;
		logic                typed;
		status_t             st;
		logic [BIN_W-1:0]    bin;
		logic [USED_W-1:0]   used;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ITEM_W-1:0] item_weight = '0;
	logic last_item = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_data = '0;
	logic busy;
	logic done;
	logic [STATUS_W-1:0] status;
	logic [BIN_W-1:0] bin_index;
	logic [USED_W-1:0] bins_used;
	logic set_done;

	always #1 clk = ~clk;

	best_fit_bin_packer_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item_weight (item_weight),
		.last_item   (last_item),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.done        (done),
		.status      (status),
		.bin_index   (bin_index),
		.bins_used   (bins_used),
		.set_done    (set_done)
	);

	// ------------------------------------------------------------------
	// Packing predictor: its own copy of the bin table and the capacity.
	// ------------------------------------------------------------------
	logic [CAP_W-1:0] capacity = CAP_RESET;
	logic [ITEM_W-1:0] bin_room [NBINS];
	int bins_open = 0;
	bit set_bad = 1'b0;

	packing_t expected_q [$];
	plan_row_t plan_q [$];
	int errors = 0;
	int words_sent = 0;

	// Best fit: among open bins with enough room, the one with least room
	// left, lowest index on a tie; otherwise open a new bin. Error checks go
	// failed set, zero weight, too heavy, table full, in that order.
	function automatic packing_t place_item(input logic [ITEM_W-1:0] w, input logic last);
		packing_t r;
		int best;
		logic [ITEM_W-1:0] best_room;
		r = '0;
		r.status = ST_FAILED;
		best = -1;
		best_room = '0;
		if (set_bad) begin
			r.status = ST_FAILED;
		end else if (w == 0) begin
			r.status = ST_ZERO;
			set_bad = 1'b1;
		end else if (w > capacity) begin
			r.status = ST_HEAVY;
			set_bad = 1'b1;
		end else begin
			for (int k = 0; k < bins_open; k++) begin
				if (bin_room[k] >= w && (best < 0 || bin_room[k] < best_room)) begin
					best = k;
					best_room = bin_room[k];
				end
			end
			if (best >= 0) begin
				bin_room[best] = bin_room[best] - w;
				r.bin = best[BIN_W-1:0];
				r.status = ST_EXISTING;
			end else if (bins_open >= NBINS) begin
				r.status = ST_FULL;
				set_bad = 1'b1;
			end else begin
				bin_room[bins_open] = capacity - w;
				r.bin = bins_open[BIN_W-1:0];
				bins_open++;
				r.status = ST_NEW;
			end
		end
		r.used = bins_open[USED_W-1:0];
		r.set_done = last;
		// the set closes after its result is formed, whatever the status
		if (last) begin
			bins_open = 0;
			set_bad = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driving. Everything changes by NBA right after a rising edge, so the
	// DUT samples stable values and we read its pre-edge outputs.
	// ------------------------------------------------------------------

	// Present a word and hold start until the edge where busy is low.
	// start is left high so back-to-back words need no second NBA.
	task automatic send_word(input logic [ITEM_W-1:0] w, input logic last);
		item_weight <= w;
		last_item <= last;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		expected_q.push_back(place_item(w, last));
		words_sent++;
	endtask

	// Capacity only changes with nothing in flight: every expected word back
	// and busy low. This is also where the sender pauses to drain.
	task automatic set_capacity(input logic [CAP_W-1:0] c);
		start <= 1'b0;
		while (expected_q.size() != 0 || busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity = c;
	endtask

	task automatic add_row(input logic set_cap, input logic [CAP_W-1:0] cap,
			input logic [ITEM_W-1:0] weight, input logic last, input int count,
			input logic typed, input status_t st, input logic [BIN_W-1:0] bin,
			input logic [USED_W-1:0] used);
		plan_row_t row;
		row.set_cap = set_cap;
		row.cap = cap;
		row.weight = weight;
		row.last = last;
		row.count = count[7:0];
		row.typed = typed;
		row.st = st;
		row.bin = bin;
		row.used = used;
		plan_q.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every done word is compared with the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		packing_t exp_w;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$error("result word with none expected: status %0d bin %0d used %0d",
					status, bin_index, bins_used);
				errors++;
			end else begin
				exp_w = expected_q.pop_front();
				if (status !== exp_w.status) begin
					$error("status: expected %0d, got %0d", exp_w.status, status);
					errors++;
				end
				if (bin_index !== exp_w.bin) begin
					$error("bin_index: expected %0d, got %0d", exp_w.bin, bin_index);
					errors++;
				end
				if (bins_used !== exp_w.used) begin
					$error("bins_used: expected %0d, got %0d", exp_w.used, bins_used);
					errors++;
				end
				if (set_done !== exp_w.set_done) begin
					$error("set_done: expected %0d, got %0d", exp_w.set_done, set_done);
					errors++;
				end
			end
		end
	end

	// Watchdog: any accepted word on either side restarts the count.
	int stall_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	plan_row_t row;
	packing_t typed_res;
	logic [ITEM_W-1:0] w;
	logic last;
	int c;
	int phase = 0;
	int set_len;
	int burst_left = 1;
	int gap;
	bit quiet;
	bit fill;

	initial begin
		// directed plan; capacity is still the reset value of 10 at first
		add_row(0, 0, 16'd0, 0, 1, 1, ST_ZERO, 0, 0);     // zero weight fails set
		add_row(0, 0, 16'd5, 1, 1, 1, ST_FAILED, 0, 0);   // rejected, closes set
		add_row(0, 0, 16'd11, 1, 1, 1, ST_HEAVY, 0, 0);   // one over capacity
		add_row(0, 0, 16'd10, 0, 1, 1, ST_NEW, 0, 1);     // exactly fills bin 0
		add_row(0, 0, 16'd3, 0, 1, 1, ST_NEW, 1, 2);
		add_row(0, 0, 16'd4, 0, 1, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'd6, 0, 1, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'd7, 0, 1, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'd3, 0, 1, 0, ST_EXISTING, 0, 0); // tie on room, low index
		add_row(0, 0, 16'd4, 1, 1, 0, ST_EXISTING, 0, 0);
		// widest capacity, full-scale weights
		add_row(1, 16'hFFFF, 16'hFFFF, 0, 1, 1, ST_NEW, 0, 1);
		add_row(0, 0, 16'hFFFF, 0, 1, 1, ST_NEW, 1, 2);
		add_row(0, 0, 16'd1, 0, 1, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'hFFFE, 1, 1, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'h5555, 0, 1, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'hAAAA, 1, 1, 0, ST_EXISTING, 0, 0);
		// capacity 1: every word opens a bin until the table is full
		add_row(1, 16'd1, 16'd1, 0, NBINS, 0, ST_EXISTING, 0, 0);
		add_row(0, 0, 16'd1, 0, 1, 1, ST_FULL, 0, NBINS);
		add_row(0, 0, 16'd1, 0, 1, 1, ST_FAILED, 0, NBINS);
		add_row(0, 0, 16'd0, 1, 1, 1, ST_FAILED, 0, NBINS); // failed wins over zero
		add_row(0, 0, 16'd2, 1, 1, 1, ST_HEAVY, 0, 0);
		add_row(0, 0, 16'd1, 1, 1, 1, ST_NEW, 0, 1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_q[i]) begin
			row = plan_q[i];
			if (row.set_cap)
				set_capacity(row.cap);
			for (int n = 0; n < row.count; n++)
				send_word(row.weight, row.last);
			if (row.typed) begin
				typed_res.status = row.st;
				typed_res.bin = row.bin;
				typed_res.used = row.used;
				typed_res.set_done = row.last;
				expected_q[expected_q.size() - 1] = typed_res;
			end
		end

		// Random phases: each picks a capacity (idle write), then sends sets of
		// well-formed words with a sprinkling of zero, heavy and raw weights.
		// Some sets are long and bin-hungry so the table fills up.
		while (words_sent < RANDOM_WORDS) begin
			phase++;
			case ($urandom_range(0, 5))
				0: c = 1;
				1: c = 65535;
				2: c = $urandom_range(2, 16);
				3: c = $urandom_range(17, 1000);
				default: c = $urandom_range(1, 65535);
			endcase
			set_capacity(c[CAP_W-1:0]);
			quiet = (phase % 3 == 0);
			for (int left = $urandom_range(100, 200); left > 0; left -= set_len) begin
				fill = ($urandom_range(0, 7) == 0);
				set_len = fill ? $urandom_range(NBINS + 1, NBINS + 6) : $urandom_range(1, 24);
				for (int j = 0; j < set_len; j++) begin
					// occasionally close a set early
					last = (j == set_len - 1) || ($urandom_range(0, 63) == 0);
					if (fill) begin
						w = ITEM_W'($urandom_range(c / 2 + 1, c));
					end else begin
						case ($urandom_range(0, 31))
							0: w = '0;
							1: w = (c == 65535) ? 16'hFFFF
								: ITEM_W'($urandom_range(c + 1, 65535));
							2: w = ITEM_W'($urandom_range(0, 65535));
							3, 4, 5, 6, 7, 8: w = ITEM_W'($urandom_range(1, (c + 3) / 4));
							default: w = ITEM_W'($urandom_range(1, c));
						endcase
					end
					send_word(w, last);
					// bursts of words with random gaps; every third phase runs flat out
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 70)
							: $urandom_range(0, 3);
						if (!quiet && gap > 0) begin
							start <= 1'b0;
							repeat (gap) @(posedge clk);
						end
					end
				end
			end
		end

		// drain, then give a stray word time to show up
		start <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (NBINS + 8) @(posedge clk);
		if (expected_q.size() != 0) begin
			$error("%0d result words never arrived", expected_q.size());
			errors++;
		end
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/bfbp_pkg.sv
src/bfbp_cell.sv
src/best_fit_bin_packer_core.sv
test/tb.sv
